// File: rtl/avd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package avd_pkg;

   // default width of the source counter and of emitted neighbor ids
   localparam int ID_BITS_DEFAULT = 32;

   // varint byte layout
   localparam logic [7:0] VARINT_CONT_MASK  = 8'h80;
   localparam logic [7:0] VARINT_DATA_MASK  = 8'h7F;
   localparam logic [7:0] VARINT_LAST_MASK  = 8'hFE;

   // byte count at which the degree varint is forced to end
   localparam logic [3:0] VARINT_LAST_COUNT = 4'd9;

   // index of the last byte of a neighbor id
   localparam logic [1:0] NEIGHBOR_LAST_BYTE = 2'd3;

   typedef enum logic {
      STATUS_EDGE     = 1'b0,
      STATUS_OVERFLOW = 1'b1
   } status_type;

endpackage

`default_nettype wire

// File: rtl/adjacency_varint_edge_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake            payload
// req      in   req_valid/req_ready  req_data_byte[7:0]
// rsp      out  rsp_valid/rsp_ready  rsp_source_node[31:0], rsp_target_node[31:0], rsp_status
//
// one byte is taken per cycle; each byte updates the decode state in the cycle it is taken
// and an edge or error word appears on rsp in the cycle after the byte that completes it.
// a single result register sits on rsp; req_ready stays high while that register is
// empty or being drained, so the input only stalls when rsp is held off with a word waiting.
// reset is synchronous, active high, and clears all decode state and the error halt.
module adjacency_varint_edge_decoder_core #(
   parameter int ID_BITS = avd_pkg::ID_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [31:0] rsp_source_node,
   output      logic [31:0] rsp_target_node,
   output      logic        rsp_status
);

   localparam logic [31:0] TARGET_MASK = (ID_BITS >= 32) ? 32'hFFFF_FFFF :
                                         32'((64'd1 << ID_BITS) - 64'd1);

   logic               phase_ff, phase_in;
   logic [3:0]         vcount_ff, vcount_in;
   logic [31:0]        degree_acc_ff, degree_acc_in;
   logic [31:0]        remaining_ff, remaining_in;
   logic [1:0]         nbyte_idx_ff, nbyte_idx_in;
   logic [23:0]        partial_ff, partial_in;
   logic [ID_BITS-1:0] source_ff, source_in;
   logic               seen_first_ff, seen_first_in;
   logic               halted_ff, halted_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_source_ff, rsp_source_in;
   logic [31:0]        rsp_target_ff, rsp_target_in;
   avd_pkg::status_type rsp_status_ff, rsp_status_in;

   logic               accept;
   logic               emit;
   logic [31:0]        degree_add;
   logic [63:0]        source_wide;
   logic [31:0]        target_full;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign source_wide = 64'(source_ff);
   assign target_full = {req_data_byte, partial_ff};

   // varint payload bits above bit 31 are dropped
   always_comb begin
      degree_add = '0;
      unique case (vcount_ff)
         4'd0:    degree_add[6:0]   = req_data_byte[6:0];
         4'd1:    degree_add[13:7]  = req_data_byte[6:0];
         4'd2:    degree_add[20:14] = req_data_byte[6:0];
         4'd3:    degree_add[27:21] = req_data_byte[6:0];
         4'd4:    degree_add[31:28] = req_data_byte[3:0];
         default: degree_add        = '0;
      endcase
   end

   always_comb begin
      logic finish;
      logic [31:0] new_degree;

      phase_in       = phase_ff;
      vcount_in      = vcount_ff;
      degree_acc_in  = degree_acc_ff;
      remaining_in   = remaining_ff;
      nbyte_idx_in   = nbyte_idx_ff;
      partial_in     = partial_ff;
      source_in      = source_ff;
      seen_first_in  = seen_first_ff;
      halted_in      = halted_ff;
      emit           = 1'b0;
      rsp_source_in  = rsp_source_ff;
      rsp_target_in  = rsp_target_ff;
      rsp_status_in  = rsp_status_ff;
      finish         = 1'b0;
      new_degree     = degree_acc_ff;

      if (accept && !halted_ff) begin
         if (phase_ff) begin
            if (nbyte_idx_ff != avd_pkg::NEIGHBOR_LAST_BYTE) begin
               unique case (nbyte_idx_ff)
                  2'd0:    partial_in[7:0]   = req_data_byte;
                  2'd1:    partial_in[15:8]  = req_data_byte;
                  default: partial_in[23:16] = req_data_byte;
               endcase
               nbyte_idx_in = nbyte_idx_ff + 2'd1;
            end else begin
               emit          = 1'b1;
               rsp_source_in = source_wide[31:0];
               rsp_target_in = target_full & TARGET_MASK;
               rsp_status_in = avd_pkg::STATUS_EDGE;
               nbyte_idx_in  = '0;
               partial_in    = '0;
               remaining_in  = remaining_ff - 32'd1;
               if (remaining_ff == 32'd1) begin
                  phase_in = 1'b0;
               end
            end
         end else if (vcount_ff >= avd_pkg::VARINT_LAST_COUNT) begin
            if ((req_data_byte & avd_pkg::VARINT_LAST_MASK) != 8'd0) begin
               emit          = 1'b1;
               halted_in     = 1'b1;
               rsp_source_in = source_wide[31:0];
               rsp_target_in = '0;
               rsp_status_in = avd_pkg::STATUS_OVERFLOW;
            end else begin
               finish = 1'b1;
            end
         end else begin
            new_degree    = degree_acc_ff | degree_add;
            degree_acc_in = new_degree;
            if ((req_data_byte & avd_pkg::VARINT_CONT_MASK) != 8'd0) begin
               vcount_in = vcount_ff + 4'd1;
            end else begin
               finish = 1'b1;
            end
         end

         // degree complete: open the next node record
         if (finish) begin
            if (seen_first_ff) begin
               source_in = source_ff + ID_BITS'(1);
            end
            seen_first_in = 1'b1;
            remaining_in  = new_degree;
            degree_acc_in = '0;
            vcount_in     = '0;
            nbyte_idx_in  = '0;
            partial_in    = '0;
            phase_in      = (new_degree != 32'd0);
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 1'b0;
         vcount_ff     <= '0;
         degree_acc_ff <= '0;
         remaining_ff  <= '0;
         nbyte_idx_ff  <= '0;
         partial_ff    <= '0;
         source_ff     <= '0;
         seen_first_ff <= 1'b0;
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         vcount_ff     <= vcount_in;
         degree_acc_ff <= degree_acc_in;
         remaining_ff  <= remaining_in;
         nbyte_idx_ff  <= nbyte_idx_in;
         partial_ff    <= partial_in;
         source_ff     <= source_in;
         seen_first_ff <= seen_first_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_source_ff <= rsp_source_in;
      rsp_target_ff <= rsp_target_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_source_node = rsp_source_ff;
   assign rsp_target_node = rsp_target_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // once halted, an empty result register never fills again
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      halted_ff && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("word produced after overflow halt");

   // neighbor phase always has neighbors left to read
   a_phase_remaining: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> remaining_ff != 32'd0)
      else $error("neighbor phase with zero remaining degree");

   // an overflow word is only ever shown together with the halt
   a_overflow_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == avd_pkg::STATUS_OVERFLOW |-> halted_ff)
      else $error("overflow word without halt");

   // varint byte count never runs past the forced last byte
   a_vcount_range: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= avd_pkg::VARINT_LAST_COUNT)
      else $error("varint byte count out of range");
`endif

endmodule

`default_nettype wire

// File: sim/adjacency_varint_edge_decoder_core_test.sv
`timescale 1ns / 1ps

module adjacency_varint_edge_decoder_core_test;

   typedef struct packed {
      logic [31:0]         source;
      logic [31:0]         target;
      avd_pkg::status_type status;
   } edge_word_type;

   typedef struct packed {
      logic [7:0]    data;
      logic          typed;
      edge_word_type want;
   } script_row_type;

   localparam edge_word_type NO_WORD = '0;
   localparam int SCRIPT_ROWS   = 32;
   localparam int OPENING_ROWS  = 20;
   localparam int RANDOM_BYTES  = 1330;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_source_node;
   logic [31:0] rsp_target_node;
   logic        rsp_status;

   bit            steady = 1'b0;
   int            bytes_sent = 0;
   int            mismatches = 0;
   int            quiet_cycles = 0;
   edge_word_type edge_words[$];

   // decoder shadow state
   logic        in_list = 1'b0;
   logic [3:0]  varint_len = '0;
   logic [31:0] degree_sum = '0;
   logic [31:0] edges_left = '0;
   logic [1:0]  id_byte = '0;
   logic [23:0] id_low = '0;
   logic [31:0] node_id = '0;
   logic        node_started = 1'b0;
   logic        stopped = 1'b0;

   // opening rows run right after reset; the overflow rows close the run since
   // the block stays halted after them
   script_row_type script [SCRIPT_ROWS] = '{
      {8'h01, 1'b0, NO_WORD},
      {8'h00, 1'b0, NO_WORD}, {8'h00, 1'b0, NO_WORD}, {8'h00, 1'b0, NO_WORD},
      {8'h00, 1'b1, 32'd0, 32'd0, avd_pkg::STATUS_EDGE},
      // ten byte varint of degree zero, last byte keeps bit 0 only
      {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD},
      {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD},
      {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD},
      {8'h01, 1'b0, NO_WORD},
      {8'h01, 1'b0, NO_WORD},
      {8'hFF, 1'b0, NO_WORD}, {8'hFF, 1'b0, NO_WORD}, {8'hFF, 1'b0, NO_WORD},
      {8'hFF, 1'b1, 32'd2, 32'hFFFF_FFFF, avd_pkg::STATUS_EDGE},
      // tenth byte with bit 1 set, then bytes that must be dropped
      {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD},
      {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD},
      {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD},
      {8'h02, 1'b0, NO_WORD},
      {8'h7F, 1'b0, NO_WORD}, {8'hFF, 1'b0, NO_WORD}
   };

   adjacency_varint_edge_decoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_source_node (rsp_source_node),
      .rsp_target_node (rsp_target_node),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void close_degree();
      if (node_started) node_id = node_id + 1;
      node_started = 1'b1;
      edges_left = degree_sum;
      degree_sum = '0;
      varint_len = '0;
      id_byte = '0;
      id_low = '0;
      in_list = (edges_left != 0);
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, output edge_word_type w);
      w = NO_WORD;
      if (stopped) return 1'b0;
      if (in_list) begin
         if (id_byte < avd_pkg::NEIGHBOR_LAST_BYTE) begin
            id_low = id_low | ({16'd0, b} << (8 * id_byte));
            id_byte = id_byte + 1'b1;
            return 1'b0;
         end
         w.source = node_id;
         w.target = {b, id_low};
         w.status = avd_pkg::STATUS_EDGE;
         id_byte = '0;
         id_low = '0;
         edges_left = edges_left - 1;
         if (edges_left == 0) in_list = 1'b0;
         return 1'b1;
      end
      if (varint_len >= avd_pkg::VARINT_LAST_COUNT) begin
         if ((b & avd_pkg::VARINT_LAST_MASK) != 0) begin
            stopped = 1'b1;
            w.source = node_id;
            w.target = '0;
            w.status = avd_pkg::STATUS_OVERFLOW;
            return 1'b1;
         end
         close_degree();
         return 1'b0;
      end
      // groups past bit 31 are dropped
      if (varint_len < 4'd5)
         degree_sum = degree_sum |
                      ({24'd0, b & avd_pkg::VARINT_DATA_MASK} << (7 * varint_len));
      if ((b & avd_pkg::VARINT_CONT_MASK) != 0) varint_len = varint_len + 1'b1;
      else close_degree();
      return 1'b0;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic typed, input edge_word_type want);
      edge_word_type got;
      if (!steady && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!steady && $urandom_range(99) < 8);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (decode_byte(b, got)) edge_words.push_back(typed ? want : got);
   endtask

   initial begin : stimulus
      int          row;
      int          pick;
      int          len;
      int          natural_len;
      int          i;
      bit          paused;
      logic [7:0]  nb;
      logic [31:0] degree;
      logic [63:0] degree_code;
      logic [63:0] rest;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (row = 0; row < OPENING_ROWS; row++)
         send_byte(script[row].data, script[row].typed, script[row].want);

      // records with random content; always finish the current record
      while (bytes_sent < OPENING_ROWS + RANDOM_BYTES || in_list) begin
         steady <= (bytes_sent >= 420 && bytes_sent < 720);
         if (!paused && bytes_sent >= 850) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (edge_words.size() != 0);
         end
         if (in_list) begin
            pick = $urandom_range(15);
            nb = 8'($urandom);
            if (pick == 0) nb = 8'h00;
            else if (pick == 1) nb = 8'hFF;
            send_byte(nb, 1'b0, NO_WORD);
         end else begin
            pick = $urandom_range(99);
            if (pick < 25) degree = 0;
            else if (pick < 70) degree = $urandom_range(3, 1);
            else if (pick < 92) degree = $urandom_range(12, 4);
            else degree = $urandom_range(40, 13);
            degree_code = {32'd0, degree};
            // junk above bit 31 that the block must drop
            if ($urandom_range(3) == 0) degree_code[63:32] = $urandom >> $urandom_range(31);
            natural_len = 1;
            while (natural_len < 10 && (degree_code >> (7 * natural_len)) != 0)
               natural_len++;
            // sometimes padded with empty groups up to ten bytes
            len = ($urandom_range(3) == 0) ? $urandom_range(10, natural_len) : natural_len;
            for (i = 0; i < len; i++) begin
               rest = degree_code >> (7 * i);
               send_byte({i != len - 1, rest[6:0]}, 1'b0, NO_WORD);
            end
         end
      end

      for (row = OPENING_ROWS; row < SCRIPT_ROWS; row++)
         send_byte(script[row].data, script[row].typed, script[row].want);
      req_valid <= 1'b0;
      while (edge_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin : rsp_side
      edge_word_type want;
      rsp_ready <= steady || ($urandom_range(99) >= 8);
      if (!reset && rsp_valid && rsp_ready) begin
         if (edge_words.size() == 0) begin
            flag_mismatch($sformatf("unexpected word source %h target %h status %b",
                                    rsp_source_node, rsp_target_node, rsp_status));
         end else begin
            want = edge_words.pop_front();
            if (rsp_source_node !== want.source)
               flag_mismatch($sformatf("source_node %h, want %h", rsp_source_node, want.source));
            if (rsp_target_node !== want.target)
               flag_mismatch($sformatf("target_node %h, want %h", rsp_target_node, want.target));
            if (rsp_status !== want.status)
               flag_mismatch($sformatf("status %b, want %b", rsp_status, want.status));
         end
      end
   end

   // ends the run when neither side moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
